// ===== hdl/lrip_pkg.sv =====
// Shared types, widths and constants for the lidar range image projector.
// No dependencies; every other source file uses this package.
package lrip_pkg;

   localparam int ROWS_DEF    = 16;
   localparam int COLUMNS_DEF = 1800;

   // field widths
   localparam int COORD_W    = 22;
   localparam int INTEN_W    = 16;
   localparam int RING_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int ROW_W      = 4;
   localparam int COL_W      = 11;
   localparam int CELL_W     = 15;
   localparam int RANGE_W    = 22;
   localparam int RATE_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;

   // range datapath
   localparam int SUMSQ_W = 44;
   localparam int ROOT_W  = 22;
   localparam int REM_W   = 24;
   localparam int RCNT_W  = 5;

   // angle datapath, angles in 2^-16 degree
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = 5;
   localparam int VEC_W        = 34;
   localparam int ANG_W        = 26;
   localparam int ATAN_W       = 22;
   localparam int NORM_BIT     = 29;
   localparam int ANG90        = 90 * 65536;
   localparam int DEG360       = 360 * 65536;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED    = 3'd0,
      ST_RANGE_OUT = 3'd1,
      ST_BAD_RING  = 3'd2,
      ST_SKIPPED   = 3'd3,
      ST_TAKEN     = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_RANGE = 2'd0,
      REG_MAX_RANGE = 2'd1,
      REG_RATE      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              busy;
      logic [ROOT_W-1:0] root;
      logic              inexact;
   } range_res_type;

   function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [ATAN_W-1:0] v;
      unique case (i)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/lrip_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies beyond lrip_pkg for default sizes.
module lrip_ram #(
   parameter int WIDTH = lrip_pkg::ROWS_DEF,
   parameter int DEPTH = lrip_pkg::COLUMNS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/lrip_range.sv =====
// Bit-serial sum of squares followed by a serial square root that takes the radicand two bits at a time.
// Depends on lrip_pkg.
module lrip_range (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [lrip_pkg::COORD_W-1:0]  pos_x,
   input  logic signed [lrip_pkg::COORD_W-1:0]  pos_y,
   input  logic signed [lrip_pkg::COORD_W-1:0]  pos_z,
   output lrip_pkg::range_res_type              res
);
   import lrip_pkg::*;

   logic                busy_ff, busy_in;
   logic                root_phase_ff, root_phase_in;
   logic [RCNT_W-1:0]   cnt_ff, cnt_in;
   logic [COORD_W-1:0]  mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [COORD_W-1:0]  sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [SUMSQ_W-1:0]  acc_ff, acc_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [REM_W+1:0]    rem_sh, trial;

   function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] v);
      return v[COORD_W-1] ? (~v + 1'b1) : v;
   endfunction

   always_comb begin
      busy_in       = busy_ff;
      root_phase_in = root_phase_ff;
      cnt_in        = cnt_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      mz_in         = mz_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sz_in         = sz_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      rem_sh        = {rem_ff, acc_ff[SUMSQ_W-1 -: 2]};
      trial         = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in       = 1'b1;
         root_phase_in = 1'b0;
         cnt_in        = RCNT_W'(COORD_W - 1);
         mx_in         = mag(pos_x);
         my_in         = mag(pos_y);
         mz_in         = mag(pos_z);
         sx_in         = mag(pos_x);
         sy_in         = mag(pos_y);
         sz_in         = mag(pos_z);
         acc_in        = '0;
      end else if (busy_ff && !root_phase_ff) begin
         // MSB-first shift-add of all three squares at once; the magnitudes
         // stay put, their shifted copies supply the multiplier bits
         acc_in = {acc_ff[SUMSQ_W-2:0], 1'b0}
                + (sx_ff[COORD_W-1] ? SUMSQ_W'(mx_ff) : '0)
                + (sy_ff[COORD_W-1] ? SUMSQ_W'(my_ff) : '0)
                + (sz_ff[COORD_W-1] ? SUMSQ_W'(mz_ff) : '0);
         sx_in = {sx_ff[COORD_W-2:0], 1'b0};
         sy_in = {sy_ff[COORD_W-2:0], 1'b0};
         sz_in = {sz_ff[COORD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            root_phase_in = 1'b1;
            cnt_in        = RCNT_W'(ROOT_W - 1);
            rem_in        = '0;
            root_in       = '0;
         end
      end else if (busy_ff) begin
         acc_in = {acc_ff[SUMSQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      root_phase_ff <= root_phase_in;
      cnt_ff        <= cnt_in;
      mx_ff         <= mx_in;
      my_ff         <= my_in;
      mz_ff         <= mz_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      sz_ff         <= sz_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
   end

   assign res.busy    = busy_ff;
   assign res.root    = root_ff;
   assign res.inexact = |rem_ff;
endmodule

// ===== hdl/lrip_angle.sv =====
// Iterative CORDIC atan2 and a serial restoring divide that maps the angle
// to an image column. Depends on lrip_pkg.
module lrip_angle #(
   parameter int COLUMNS = lrip_pkg::COLUMNS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lrip_pkg::COORD_W-1:0] pos_x,
   input  logic signed [lrip_pkg::COORD_W-1:0] pos_y,
   output logic                                busy,
   output logic [$clog2(COLUMNS)-1:0]          column
);
   import lrip_pkg::*;

   localparam int CLW   = $clog2(COLUMNS);
   localparam int QW    = CLW + 1;
   localparam int QCW   = $clog2(QW + 1);
   localparam int CMW   = $clog2(COLUMNS + 1);
   localparam int NUMW  = ANG_W + CMW + 2;
   localparam int DIVW  = NUMW + 2;
   localparam int SW    = CLW + 3;
   localparam logic [VEC_W-1:0] NORM_MIN = VEC_W'(1) << NORM_BIT;

   typedef enum logic [6:0] {
      A_IDLE = 7'b0000001,
      A_NORM = 7'b0000010,
      A_ROT  = 7'b0000100,
      A_MUL  = 7'b0001000,
      A_PREP = 7'b0010000,
      A_DIV  = 7'b0100000,
      A_FIN  = 7'b1000000
   } astate_type;

   astate_type               state_ff, state_in;
   logic signed [VEC_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [NUMW-1:0]   num_ff, num_in;
   logic                     neg_ff, neg_in;
   logic [DIVW-1:0]          rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QW-1:0]            q_ff, q_in;
   logic [QCW-1:0]           qcnt_ff, qcnt_in;
   logic [CLW-1:0]           col_ff, col_in;

   logic signed [VEC_W-1:0]  ya, xb, absb, sa, sb;
   logic signed [ANG_W-1:0]  atan_s;
   logic signed [NUMW-1:0]   zd, cmul;
   logic [NUMW-1:0]          nmag;
   logic signed [SW-1:0]     nq, c0;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      qcnt_in  = qcnt_ff;
      col_in   = col_ff;

      ya     = VEC_W'(pos_y);
      xb     = VEC_W'(pos_x);
      absb   = b_ff[VEC_W-1] ? -b_ff : b_ff;
      sa     = a_ff >>> step_ff;
      sb     = b_ff >>> step_ff;
      atan_s = ANG_W'(signed'({1'b0, atan_entry(step_ff)}));
      zd     = NUMW'(z_ff) - NUMW'(ANG90);
      cmul   = NUMW'(COLUMNS);
      nmag   = num_ff[NUMW-1] ? NUMW'(-num_ff) : NUMW'(num_ff);
      nq     = neg_ff ? -SW'(q_ff) : SW'(q_ff);
      c0     = SW'(COLUMNS / 2) - nq;

      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               step_in = '0;
               if (pos_x == '0 && pos_y == '0) begin
                  z_in     = '0;
                  state_in = A_MUL;
               end else begin
                  state_in = A_NORM;
                  // quadrant pre-rotation so that a is not negative
                  if (ya < 0) begin
                     if (xb >= 0) begin
                        a_in = xb;
                        b_in = -ya;
                        z_in = ANG_W'(ANG90);
                     end else begin
                        a_in = -xb;
                        b_in = ya;
                        z_in = -ANG_W'(ANG90);
                     end
                  end else begin
                     a_in = ya;
                     b_in = xb;
                     z_in = '0;
                  end
               end
            end
         end
         A_NORM: begin
            if (VEC_W'(a_ff) >= NORM_MIN || VEC_W'(absb) >= NORM_MIN) begin
               state_in = A_ROT;
            end else begin
               a_in = a_ff <<< 1;
               b_in = b_ff <<< 1;
            end
         end
         A_ROT: begin
            if (!b_ff[VEC_W-1]) begin
               a_in = a_ff + sb;
               b_in = b_ff - sa;
               z_in = z_ff + atan_s;
            end else begin
               a_in = a_ff - sb;
               b_in = b_ff + sa;
               z_in = z_ff - atan_s;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = A_MUL;
            end
         end
         A_MUL: begin
            num_in   = zd * cmul;
            state_in = A_PREP;
         end
         A_PREP: begin
            // round half away from zero: (2|num| + den) / (2 den)
            neg_in   = num_ff[NUMW-1];
            rem_in   = (DIVW'(nmag) << 1) + DIVW'(DEG360);
            dsh_in   = DIVW'(DEG360) << QW;
            q_in     = '0;
            qcnt_in  = QCW'(QW - 1);
            state_in = A_DIV;
         end
         A_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            qcnt_in = qcnt_ff - 1'b1;
            if (qcnt_ff == '0) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            if (c0 < 0) begin
               col_in = CLW'(c0 + SW'(COLUMNS));
            end else if (c0 >= SW'(COLUMNS)) begin
               col_in = CLW'(c0 - SW'(COLUMNS));
            end else begin
               col_in = CLW'(c0);
            end
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      num_ff  <= num_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      qcnt_ff <= qcnt_in;
      col_ff  <= col_in;
   end

   assign busy   = (state_ff != A_IDLE);
   assign column = col_ff;
endmodule

// ===== hdl/lidar_range_image_projector.sv =====
// Lidar range image projector: range gate, ring checks, column from the
// horizontal angle and a per-cell occupancy store. Depends on lrip_pkg,
// lrip_ram, lrip_range and lrip_angle.
// Use:
//  - req_ channel carries one word per point (or a clear, operation = 1).
//    A word is taken when req_valid is high and req_stall is low; the block
//    works on one word at a time and holds req_stall high while busy.
//  - rsp_ channel returns exactly one word per request, held in an output
//    register until rsp_stall is low; a new request is taken while it waits.
//  - csr_ port: registers min_range, max_range, downsample_rate, written at
//    any edge with csr_we high; write only while no request is in flight.
//  - Point flow: the serial square sum and root run beside the CORDIC loop and
//    column divide; the CORDIC vector, if nonzero, is first normalised by 8 to 29
//    left shifts. A point leaves the calc state once the range unit, the angle unit
//    and the ring modulo are all idle; a rejected point skips the lookup state.
//  - Clear: one occupancy RAM word (one image column) per cycle, over all COLUMNS.
//  - Reset: synchronous; registers take their defaults, then a sweep over all
//    COLUMNS addresses empties the occupancy RAM with req_stall held high.
//  - A stalled receiver only holds the finished word; the next one waits in
//    the done state until the output register frees.
module lidar_range_image_projector #(
   parameter int ROWS    = lrip_pkg::ROWS_DEF,
   parameter int COLUMNS = lrip_pkg::COLUMNS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic signed [lrip_pkg::COORD_W-1:0]    req_pos_x,
   input  logic signed [lrip_pkg::COORD_W-1:0]    req_pos_y,
   input  logic signed [lrip_pkg::COORD_W-1:0]    req_pos_z,
   input  logic [lrip_pkg::INTEN_W-1:0]           req_intensity,
   input  logic [lrip_pkg::RING_W-1:0]            req_ring,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lrip_pkg::STATUS_W-1:0]          rsp_status,
   output logic [lrip_pkg::ROW_W-1:0]             rsp_row,
   output logic [lrip_pkg::COL_W-1:0]             rsp_column,
   output logic [lrip_pkg::CELL_W-1:0]            rsp_cell_index,
   output logic [lrip_pkg::RANGE_W-1:0]           rsp_range_out,
   output logic signed [lrip_pkg::COORD_W-1:0]    rsp_out_x,
   output logic signed [lrip_pkg::COORD_W-1:0]    rsp_out_y,
   output logic signed [lrip_pkg::COORD_W-1:0]    rsp_out_z,
   output logic [lrip_pkg::INTEN_W-1:0]           rsp_out_intensity,
   input  logic                                   csr_we,
   input  logic [lrip_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lrip_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lrip_pkg::*;

   localparam int CLW   = $clog2(COLUMNS);
   localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CELLW = $clog2(ROWS * COLUMNS + 1);

   typedef enum logic [5:0] {
      S_INIT  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_CALC  = 6'b000100,
      S_LOOK  = 6'b001000,
      S_DONE  = 6'b010000,
      S_CLEAR = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [CLW-1:0]       addr_ff, addr_in;
   status_type           status_ff, status_in;
   logic [ROWS-1:0]      word_ff, word_in;

   // registers
   logic [RANGE_W-1:0]   min_range_ff, min_range_in;
   logic [RANGE_W-1:0]   max_range_ff, max_range_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;

   // captured point
   logic [COORD_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [INTEN_W-1:0]   inten_ff, inten_in;
   logic [RING_W-1:0]    ring_ff, ring_in;

   // serial ring modulo
   logic                 mod_busy_ff, mod_busy_in;
   logic [RING_W-1:0]    mod_sh_ff, mod_sh_in;
   logic [RATE_W-1:0]    mod_rem_ff, mod_rem_in;
   logic [3:0]           mod_cnt_ff, mod_cnt_in;
   logic [RATE_W-1:0]    rate_eff;
   logic [RATE_W:0]      mod_try;

   // output register
   logic                 ovalid_ff, ovalid_in;
   status_type           ostatus_ff, ostatus_in;
   logic [ROW_W-1:0]     orow_ff, orow_in;
   logic [COL_W-1:0]     ocol_ff, ocol_in;
   logic [CELL_W-1:0]    ocell_ff, ocell_in;
   logic [RANGE_W-1:0]   orange_ff, orange_in;
   logic [COORD_W-1:0]   ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [INTEN_W-1:0]   ointen_ff, ointen_in;

   logic                 accept, start, out_free, units_done, range_bad;
   logic                 sweep_last;
   logic                 ram_we;
   logic [CLW-1:0]       ram_addr;
   logic [ROWS-1:0]      ram_wdata, ram_rdata, ring_bit;
   logic [CELLW-1:0]     cell_idx;
   range_res_type        rres;
   logic                 ang_busy;
   logic [CLW-1:0]       ang_col;

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign start      = accept && !req_operation;
   assign out_free   = !ovalid_ff || !rsp_stall;
   assign units_done = !rres.busy && !ang_busy && !mod_busy_ff;
   assign sweep_last = (addr_ff == CLW'(COLUMNS - 1));
   assign ring_bit   = ROWS'(1) << ring_ff[RIW-1:0];
   assign cell_idx   = CELLW'(ring_ff) * CELLW'(COLUMNS) + CELLW'(ang_col);

   // exact range test on squares, taken through floor(sqrt) and remainder
   assign range_bad = (rres.root < min_range_ff) || (rres.root > max_range_ff)
                   || (rres.root == max_range_ff && rres.inexact);

   assign rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign mod_try  = {mod_rem_ff, mod_sh_ff[RING_W-1]};

   lrip_range u_range (
      .clock (clock),
      .reset (reset),
      .start (start),
      .pos_x (req_pos_x),
      .pos_y (req_pos_y),
      .pos_z (req_pos_z),
      .res   (rres)
   );

   // the angle is taken of the vector (y, x)
   lrip_angle #(.COLUMNS(COLUMNS)) u_angle (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .pos_x  (req_pos_x),
      .pos_y  (req_pos_y),
      .busy   (ang_busy),
      .column (ang_col)
   );

   lrip_ram #(.WIDTH(ROWS), .DEPTH(COLUMNS)) u_occ (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = ang_col;
      ram_wdata = '0;
      if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         ram_we   = 1'b1;
         ram_addr = addr_ff;
      end else if (state_ff == S_DONE && out_free && status_ff == ST_STORED) begin
         ram_we    = 1'b1;
         ram_wdata = word_ff | ring_bit;
      end
   end

   // configuration
   always_comb begin
      min_range_in = min_range_ff;
      max_range_in = max_range_ff;
      rate_in      = rate_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MIN_RANGE: min_range_in = RANGE_W'(csr_wdata);
            REG_MAX_RANGE: max_range_in = RANGE_W'(csr_wdata);
            REG_RATE:      rate_in      = RATE_W'(csr_wdata);
            default:       ;
         endcase
      end
   end

   // ring mod rate, one ring bit per cycle
   always_comb begin
      mod_busy_in = mod_busy_ff;
      mod_sh_in   = mod_sh_ff;
      mod_rem_in  = mod_rem_ff;
      mod_cnt_in  = mod_cnt_ff;
      if (start) begin
         mod_busy_in = 1'b1;
         mod_sh_in   = req_ring;
         mod_rem_in  = '0;
         mod_cnt_in  = 4'(RING_W - 1);
      end else if (mod_busy_ff) begin
         mod_rem_in = (mod_try >= {1'b0, rate_eff}) ? RATE_W'(mod_try - {1'b0, rate_eff})
                                                   : RATE_W'(mod_try);
         mod_sh_in  = {mod_sh_ff[RING_W-2:0], 1'b0};
         mod_cnt_in = mod_cnt_ff - 1'b1;
         if (mod_cnt_ff == '0) begin
            mod_busy_in = 1'b0;
         end
      end
   end

   // sequencer and output register
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      status_in  = status_ff;
      word_in    = word_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      inten_in   = inten_ff;
      ring_in    = ring_ff;
      ovalid_in  = ovalid_ff && rsp_stall;
      ostatus_in = ostatus_ff;
      orow_in    = orow_ff;
      ocol_in    = ocol_ff;
      ocell_in   = ocell_ff;
      orange_in  = orange_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      oz_in      = oz_ff;
      ointen_in  = ointen_ff;

      unique case (state_ff)
         S_INIT: begin
            addr_in = addr_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               z_in     = req_pos_z;
               inten_in = req_intensity;
               ring_in  = req_ring;
               if (req_operation) begin
                  addr_in  = '0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            // checks in order: range, ring beyond image, ring skipped;
            // a surviving point reads its column word this cycle
            if (units_done) begin
               if (range_bad) begin
                  status_in = ST_RANGE_OUT;
                  state_in  = S_DONE;
               end else if (ring_ff >= RING_W'(ROWS)) begin
                  status_in = ST_BAD_RING;
                  state_in  = S_DONE;
               end else if (mod_rem_ff != '0) begin
                  status_in = ST_SKIPPED;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            word_in   = ram_rdata;
            status_in = |(ram_rdata & ring_bit) ? ST_TAKEN : ST_STORED;
            state_in  = S_DONE;
         end
         S_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (sweep_last) begin
               status_in = ST_CLEARED;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ovalid_in  = 1'b1;
               ostatus_in = status_ff;
               orow_in    = '0;
               ocol_in    = '0;
               ocell_in   = '0;
               orange_in  = rres.root;
               ox_in      = '0;
               oy_in      = '0;
               oz_in      = '0;
               ointen_in  = '0;
               if (status_ff == ST_STORED || status_ff == ST_SKIPPED
                   || status_ff == ST_TAKEN) begin
                  orow_in = ROW_W'(ring_ff);
               end
               if (status_ff == ST_STORED || status_ff == ST_TAKEN) begin
                  ocol_in  = COL_W'(ang_col);
                  ocell_in = CELL_W'(cell_idx);
               end
               if (status_ff == ST_STORED) begin
                  ox_in     = x_ff;
                  oy_in     = y_ff;
                  oz_in     = z_ff;
                  ointen_in = inten_ff;
               end
               if (status_ff == ST_CLEARED) begin
                  orange_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         ovalid_ff    <= 1'b0;
         mod_busy_ff  <= 1'b0;
         min_range_ff <= RANGE_W'(1024);
         max_range_ff <= RANGE_W'(1024000);
         rate_ff      <= RATE_W'(1);
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         ovalid_ff    <= ovalid_in;
         mod_busy_ff  <= mod_busy_in;
         min_range_ff <= min_range_in;
         max_range_ff <= max_range_in;
         rate_ff      <= rate_in;
      end
      status_ff  <= status_in;
      word_ff    <= word_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      inten_ff   <= inten_in;
      ring_ff    <= ring_in;
      mod_sh_ff  <= mod_sh_in;
      mod_rem_ff <= mod_rem_in;
      mod_cnt_ff <= mod_cnt_in;
      ostatus_ff <= ostatus_in;
      orow_ff    <= orow_in;
      ocol_ff    <= ocol_in;
      ocell_ff   <= ocell_in;
      orange_ff  <= orange_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      oz_ff      <= oz_in;
      ointen_ff  <= ointen_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = ovalid_ff;
   assign rsp_status        = ostatus_ff;
   assign rsp_row           = orow_ff;
   assign rsp_column        = ocol_ff;
   assign rsp_cell_index    = ocell_ff;
   assign rsp_range_out     = orange_ff;
   assign rsp_out_x         = ox_ff;
   assign rsp_out_y         = oy_ff;
   assign rsp_out_z         = oz_ff;
   assign rsp_out_intensity = ointen_ff;
endmodule

// ===== bench/tb_top.sv =====
// Testbench for the lidar range image projector: a predictor of range gate,
// ring checks, CORDIC column and occupancy, with a scoreboard. Needs lrip_pkg and the projector.
`timescale 1ns / 100ps
module tb_top;
   import lrip_pkg::*;

   localparam int NROWS = ROWS_DEF;
   localparam int NCOLS = COLUMNS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic signed [COORD_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [INTEN_W-1:0] req_intensity = '0;
   logic [RING_W-1:0] req_ring = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ROW_W-1:0] rsp_row;
   logic [COL_W-1:0] rsp_column;
   logic [CELL_W-1:0] rsp_cell_index;
   logic [RANGE_W-1:0] rsp_range_out;
   logic signed [COORD_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [INTEN_W-1:0] rsp_out_intensity;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always #5 clock = ~clock;

   lidar_range_image_projector u_top (.*);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [CELL_W-1:0] cell_idx;
      logic [RANGE_W-1:0] rng;
      logic [COORD_W-1:0] x, y, z;
      logic [INTEN_W-1:0] inten;
   } proj_word_t;

   proj_word_t expected_words[$];
   bit occupied[NROWS*NCOLS];
   longint unsigned min_rng = 1024, max_rng = 1024000, ds_rate = 1;
   int errors = 0;
   int send_idle_pct = 0;   // sender gap chance
   int recv_stall_pct = 0;  // receiver stall chance
   bit hold_off = 0;        // long receiver hold-off in progress

   // -------- predictor --------
   function automatic longint shr_floor(longint v, int s);
      return v >= 0 ? (v >>> s) : ~((~v) >>> s);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned r = 0, t;
      for (int b = 23; b >= 0; b--) begin
         t = r + (64'd1 << b);
         if (t * t <= s) r = t;
      end
      return r;
   endfunction

   // angle of (a, b) in 2^-16 degree
   function automatic longint heading(longint a, longint b);
      longint z = 0, t, m, da, db;
      longint atab[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
      if (a == 0 && b == 0) return 0;
      if (a < 0) begin
         if (b >= 0) begin t = a; a = b; b = -t; z = 90*65536; end
         else begin t = a; a = -b; b = t; z = -90*65536; end
      end
      m = (b < 0) ? -b : b;
      if (a > m) m = a;
      while (m < (64'sd1 << 29)) begin a *= 2; b *= 2; m *= 2; end
      for (int i = 0; i < 20; i++) begin
         da = shr_floor(b, i); db = shr_floor(a, i);
         if (b >= 0) begin a += da; b -= db; z += atab[i]; end
         else begin a -= da; b += db; z -= atab[i]; end
      end
      return z;
   endfunction

   function automatic int column_from(longint z);
      longint num = (z - 90*65536) * NCOLS, den = 360*65536, n, c;
      if (num >= 0) n = (2*num + den) / (2*den);
      else n = -((2*(-num) + den) / (2*den));
      c = (NCOLS/2 - n) % NCOLS;
      if (c < 0) c += NCOLS;
      return int'(c);
   endfunction

   function automatic proj_word_t project(bit op, logic signed [COORD_W-1:0] px, py, pz,
                                          logic [INTEN_W-1:0] inten, logic [RING_W-1:0] ring);
      proj_word_t w = '0;
      longint x = px, y = py, z = pz;
      longint unsigned s, r, rate;
      int col, cell_idx;
      if (op) begin
         foreach (occupied[i]) occupied[i] = 0;
         w.status = ST_CLEARED;
         return w;
      end
      s = x*x + y*y + z*z;
      r = root_floor(s);
      if (r > 64'h3FFFFF) r = 64'h3FFFFF;
      w.rng = RANGE_W'(r);
      if (s < min_rng*min_rng || s > max_rng*max_rng) begin
         w.status = ST_RANGE_OUT; return w;
      end
      if (ring >= NROWS) begin w.status = ST_BAD_RING; return w; end
      w.row = ring[3:0];
      rate = ds_rate ? ds_rate : 1;
      if (ring % rate != 0) begin w.status = ST_SKIPPED; return w; end
      col = column_from(heading(y, x));
      cell_idx = ring * NCOLS + col;
      w.column = COL_W'(col); w.cell_idx = CELL_W'(cell_idx);
      if (occupied[cell_idx]) begin w.status = ST_TAKEN; return w; end
      occupied[cell_idx] = 1;
      w.status = ST_STORED;
      w.x = px; w.y = py; w.z = pz; w.inten = inten;
      return w;
   endfunction

   // -------- driving --------
   task automatic send_point(bit op, logic signed [COORD_W-1:0] x, y, z,
                             logic [INTEN_W-1:0] inten, logic [RING_W-1:0] ring);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_operation <= op;
      req_pos_x <= x; req_pos_y <= y; req_pos_z <= z;
      req_intensity <= inten; req_ring <= ring;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words = {expected_words, project(op, x, y, z, inten, ring)};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      case (idx)
         REG_MIN_RANGE: min_rng = v;
         REG_MAX_RANGE: max_rng = v;
         REG_RATE:      ds_rate = v[RATE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_gates(int lo, int hi, int rate);
      drain();
      write_reg(REG_MIN_RANGE, CSR_DATA_W'(lo));
      write_reg(REG_MAX_RANGE, CSR_DATA_W'(hi));
      write_reg(REG_RATE, CSR_DATA_W'(rate));
      csr_we <= 1'b0;
   endtask

   // random point; mostly in range, small ring
   task automatic send_random_point();
      logic signed [COORD_W-1:0] x, y, z;
      int k = $urandom_range(99);
      bit op = ($urandom_range(199) == 0);
      if (k < 70) begin
         x = COORD_W'($signed($urandom_range(0, 200000)) - 100000);
         y = COORD_W'($signed($urandom_range(0, 200000)) - 100000);
         z = COORD_W'($signed($urandom_range(0, 20000)) - 10000);
      end else begin
         x = COORD_W'($urandom); y = COORD_W'($urandom); z = COORD_W'($urandom);
      end
      send_point(op, x, y, z, INTEN_W'($urandom),
                 (k < 85) ? RING_W'($urandom_range(15)) : RING_W'($urandom));
   endtask

   // -------- checking --------
   always @(posedge clock) begin
      proj_word_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("result word with none expected");
            errors++;
         end else begin
            e = expected_words[0];
            expected_words.delete(0);
            if (rsp_status != e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++; end
            if (rsp_row != e.row) begin
               $error("row exp %0d got %0d", e.row, rsp_row); errors++; end
            if (rsp_column != e.column) begin
               $error("column exp %0d got %0d", e.column, rsp_column); errors++; end
            if (rsp_cell_index != e.cell_idx) begin
               $error("cell_index exp %0d got %0d", e.cell_idx, rsp_cell_index); errors++; end
            if (rsp_range_out != e.rng) begin
               $error("range_out exp %0d got %0d", e.rng, rsp_range_out); errors++; end
            if (rsp_out_x != e.x) begin
               $error("out_x exp %h got %h", e.x, rsp_out_x); errors++; end
            if (rsp_out_y != e.y) begin
               $error("out_y exp %h got %h", e.y, rsp_out_y); errors++; end
            if (rsp_out_z != e.z) begin
               $error("out_z exp %h got %h", e.z, rsp_out_z); errors++; end
            if (rsp_out_intensity != e.inten) begin
               $error("out_intensity exp %h got %h", e.inten, rsp_out_intensity);
               errors++;
            end
         end
      end
   end

   // receiver stall, with a long counted hold-off when asked
   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
   end

   // -------- tests --------
   task automatic test_directed();
      send_point(0, 0, 0, 0, 0, 0);                       // zero vector, out of range
      send_point(0, 1024, 0, 0, 16'hFFFF, 0);             // on min edge
      send_point(0, 1024, 0, 0, 0, 0);                    // same cell again: taken
      send_point(0, 0, 1024, 0, 16'h1234, 0);
      send_point(0, -1024, 0, 0, 1, 1);
      send_point(0, 0, -1024, 0, 2, 2);
      send_point(0, -1024, -1, 5, 3, 3);                  // near the wrap seam
      send_point(0, -1024, 1, 5, 3, 3);
      send_point(0, 22'sh1FFFFF, 22'sh1FFFFF, 22'sh1FFFFF, 0, 4); // beyond max
      send_point(0, -22'sh200000, -22'sh200000, -22'sh200000, 0, 4);
      send_point(0, 2000, 3000, -4000, 7, 16);            // bad ring
      send_point(0, 2000, 3000, -4000, 7, 255);
      send_point(0, 5000, -7000, 100, 9, 15);
      send_point(1, 22'sh1FFFFF, -1, 3, 16'hFFFF, 255);   // clear
      send_point(0, 1024, 0, 0, 5, 0);                    // stored again after clear
      set_gates(0, 4194303, 16);
      send_point(0, 0, 0, 0, 0, 0);
      send_point(0, 22'sh1FFFFF, 22'sh1FFFFF, 22'sh1FFFFF, 0, 0); // large range, in the gate
      send_point(0, 3000, 3000, 0, 0, 8);                 // skipped
      send_point(0, 3000, -3000, 0, 0, 15);
      set_gates(5000, 5000, 0);                           // zero rate acts as one
      send_point(0, 5000, 0, 0, 0, 7);
      send_point(0, 5001, 0, 0, 0, 7);
      send_point(0, 4999, 0, 0, 0, 7);
   endtask

   task automatic test_random(int n, int idle, int stall);
      send_idle_pct = idle; recv_stall_pct = stall;
      repeat (n) send_random_point();
   endtask

   task automatic test_hold_off();
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         repeat (40) send_random_point();
      join
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_gates(1024, 1024000, 1);
      test_random(450, 0, 0);
      set_gates(100, 150000, 2);
      test_random(450, 47, 0);
      set_gates(30000, 4194303, 3);
      test_random(450, 0, 47);
      set_gates(1024, 120000, 1);
      test_hold_off();
      test_random(450, 13, 13);
      send_idle_pct = 0; recv_stall_pct = 0;
      drain();
      if (errors == 0)
         $display("lidar_range_image_projector test passed");
      else
         $display("lidar_range_image_projector test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("lidar_range_image_projector test failed");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/lrip_pkg.sv
hdl/lrip_ram.sv
hdl/lrip_range.sv
hdl/lrip_angle.sv
hdl/lidar_range_image_projector.sv
bench/tb_top.sv
